// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the shortest-path unit RTL.
// Each macro checks on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: a holds, so b holds.
`define DGSP_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dgsp: same-cycle check failed");

// Next-cycle implication: a holds, so b holds in the next cycle.
`define DGSP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dgsp: next-cycle check failed");

`endif

// ===== rtl/core/dgsp_pkg.sv =====
// ============================================================================
// dgsp_pkg
// Shared sizes, codes, types and helpers of the shortest-path unit.
// ============================================================================
`default_nettype none

package dgsp_pkg;

    // Graph size and stored weight width
    localparam int NUM_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;

    // Field widths of the word interface
    localparam int VFIELD_W = 4;
    localparam int WFIELD_W = 16;
    localparam int DIST_W   = 24;

    // Derived sizes
    localparam int VIDX_W    = $clog2(NUM_VERTICES);
    localparam int ADDR_W    = 2 * VIDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int SUM_W     = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;
    localparam int OUT_COUNT = (NUM_VERTICES < 16) ? NUM_VERTICES : 16;
    localparam int OUT_W     = $clog2(OUT_COUNT);
    localparam int K_W       = $clog2(NUM_VERTICES + 2);
    localparam int PASS_W    = $clog2(NUM_VERTICES);
    localparam int VEXT_W    = (VFIELD_W > VIDX_W) ? VFIELD_W : VIDX_W;
    localparam int WEXT_W    = (WFIELD_W > WEIGHT_BITS) ? WFIELD_W : WEIGHT_BITS;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    typedef logic [VIDX_W-1:0]      t_vidx;
    typedef logic [DIST_W-1:0]      t_dist;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [ADDR_W-1:0]      t_addr;

    // Item action codes
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_RUN   = 1'b1
    } t_action;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PASS,
        S_OUT
    } t_state;

    // Token that walks the cell chain once per pass
    typedef struct packed {
        logic  valid;
        logic  settle_en;
        logic  relax_en;
        t_vidx pick_idx;
        t_dist pick_dist;
        t_dist least;
        t_vidx best_idx;
        logic  found;
    } t_token;

    // Broadcast control to every cell
    typedef struct packed {
        logic init;
        logic shift;
    } t_cell_ctl;

    // Fit a vertex field to the internal index width
    function automatic t_vidx fit_vidx(input logic [VFIELD_W-1:0] x);
        logic [VEXT_W-1:0] ext;
        ext = VEXT_W'(x);
        return ext[VIDX_W-1:0];
    endfunction

    // Fit a weight field to the stored weight width
    function automatic t_weight fit_weight(input logic [WFIELD_W-1:0] x);
        logic [WEXT_W-1:0] ext;
        ext = WEXT_W'(x);
        return ext[WEIGHT_BITS-1:0];
    endfunction

    // Vertex field names an existing vertex
    function automatic logic vidx_ok(input logic [VFIELD_W-1:0] x);
        return int'(x) < NUM_VERTICES;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dense_graph_shortest_paths_unit.sv =====
// ============================================================================
// dense_graph_shortest_paths_unit
// Single-source shortest paths over a dense weighted adjacency matrix,
// computed by a chain of vertex cells fed from an edge weight RAM.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  command | in        | start high, busy low   | action, row/column, weight, src
//  result  | out       | o_result_valid strobe  | vertex, distance, reachable, last
//
//  A weight write leaves busy low, so writes can stream.
//  A run is a series of NUM_VERTICES passes (one RAM row read per pass, one
//  token walking the cell chain) followed by the readout of the results.
//  After reset, busy stays high while the weight RAM is cleared one word per cycle.
//  Results come one per cycle and cannot be stalled.
//
`default_nettype none
`include "assert_macros.svh"

module dense_graph_shortest_paths_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_action,
    input  wire logic [dgsp_pkg::VFIELD_W-1:0]  i_row_index,
    input  wire logic [dgsp_pkg::VFIELD_W-1:0]  i_column_index,
    input  wire logic [dgsp_pkg::WFIELD_W-1:0]  i_edge_weight,
    input  wire logic [dgsp_pkg::VFIELD_W-1:0]  i_source_vertex,
    output logic                                o_result_valid,
    output logic [dgsp_pkg::VFIELD_W-1:0]       o_vertex_index,
    output logic [dgsp_pkg::DIST_W-1:0]         o_path_distance,
    output logic                                o_reachable,
    output logic                                o_last_of_run
);

    import dgsp_pkg::*;

    localparam logic [K_W-1:0]    K_LAUNCH  = K_W'(1);
    localparam logic [K_W-1:0]    K_LAST    = K_W'(NUM_VERTICES + 1);
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(NUM_VERTICES - 1);
    localparam logic [OUT_W-1:0]  OUT_LAST  = OUT_W'(OUT_COUNT - 1);

    t_state              r_state;
    t_state              n_state;
    t_addr               r_clr_addr;
    logic [K_W-1:0]      r_k;
    logic [PASS_W-1:0]   r_pass;
    t_vidx               r_pick;
    t_dist               r_least;
    logic                r_found;
    logic [OUT_W-1:0]    r_out_cnt;
    logic                r_res_valid;
    logic [OUT_W-1:0]    r_res_idx;
    t_dist               r_res_dist;
    logic                r_res_last;

    logic                w_accept;
    logic                w_run;
    logic                w_pass_end;
    logic                w_ram_we;
    t_addr               w_ram_waddr;
    t_weight             w_ram_wdata;
    t_addr               w_ram_raddr;
    t_weight             w_ram_rdata;
    t_cell_ctl           w_ctl;
    t_token              w_launch;
    t_token              w_tok [NUM_VERTICES+1];
    t_dist               w_dist [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] w_init_hot;

    assign w_accept   = start & ~busy;
    assign w_run      = w_accept & (t_action'(i_action) == ACT_RUN);
    assign w_pass_end = (r_state == S_PASS) && (r_k == K_LAST);
    assign w_tok[0]   = w_launch;

    // Edge weight store
    dgsp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Mark the source cell for initialization
    always_comb begin
        for (int v = 0; v < NUM_VERTICES; v++) begin
            w_init_hot[v] = vidx_ok(i_source_vertex)
                            & (fit_vidx(i_source_vertex) == VIDX_W'(v));
        end
    end

    // Chain of vertex cells
    for (genvar g = 0; g < NUM_VERTICES; g++) begin : g_cell
        t_dist w_next_dist;
        if (g == NUM_VERTICES - 1) begin : g_tail
            assign w_next_dist = DIST_INF;
        end else begin : g_body
            assign w_next_dist = w_dist[g+1];
        end

        dgsp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_idx        (VIDX_W'(g)),
            .i_init_src   (w_init_hot[g]),
            .i_weight     (w_ram_rdata),
            .i_tok        (w_tok[g]),
            .o_tok        (w_tok[g+1]),
            .i_shift_dist (w_next_dist),
            .o_dist       (w_dist[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE:  if (w_run) n_state = S_PASS;
            S_PASS:  if ((r_k == K_LAST) && (r_pass == PASS_LAST)) n_state = S_OUT;
            S_OUT:   if (r_out_cnt == OUT_LAST) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs: RAM port, cell control, token launch
    always_comb begin
        busy        = 1'b1;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr_addr;
        w_ram_wdata = '0;
        w_ram_raddr = {r_pick, r_k[VIDX_W-1:0]};
        w_ctl       = '0;
        w_launch    = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we = 1'b1;
            end
            S_IDLE: begin
                busy        = 1'b0;
                w_ram_we    = start & (t_action'(i_action) == ACT_WRITE)
                              & vidx_ok(i_row_index) & vidx_ok(i_column_index);
                w_ram_waddr = {fit_vidx(i_row_index), fit_vidx(i_column_index)};
                w_ram_wdata = fit_weight(i_edge_weight);
                w_ctl.init  = w_run;
            end
            S_PASS: begin
                w_launch.valid     = (r_k == K_LAUNCH);
                w_launch.settle_en = r_found;
                w_launch.relax_en  = r_found & (r_least != DIST_INF);
                w_launch.pick_idx  = r_pick;
                w_launch.pick_dist = r_least;
                w_launch.least     = DIST_INF;
            end
            S_OUT: begin
                w_ctl.shift = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers: state, clear sweep, pass and readout counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_pass      <= '0;
            r_found     <= 1'b0;
            r_out_cnt   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == S_OUT);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_OUT) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end else begin
                r_out_cnt <= '0;
            end
            if (w_run) begin
                r_k     <= '0;
                r_pass  <= '0;
                r_found <= 1'b0;
            end else if (r_state == S_PASS) begin
                if (r_k == K_LAST) begin
                    r_k     <= '0;
                    r_pass  <= r_pass + 1'b1;
                    r_found <= w_tok[NUM_VERTICES].found;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // Latch the pick at the end of each pass, register each result word
    always_ff @(posedge i_clk) begin
        if (w_pass_end) begin
            r_pick  <= w_tok[NUM_VERTICES].best_idx;
            r_least <= w_tok[NUM_VERTICES].least;
        end
        r_res_idx  <= r_out_cnt;
        r_res_dist <= w_dist[0];
        r_res_last <= (r_out_cnt == OUT_LAST);
    end

    assign o_result_valid  = r_res_valid;
    assign o_vertex_index  = VFIELD_W'(r_res_idx);
    assign o_path_distance = r_res_dist;
    assign o_reachable     = (r_res_dist != DIST_INF);
    assign o_last_of_run   = r_res_last;

    // Checks
    `DGSP_ASSERT_NEXT(a_run_goes_busy, i_clk, i_rst_n, w_run, busy)
    `DGSP_ASSERT_IMPLY(a_tok_exit_timing, i_clk, i_rst_n, w_tok[NUM_VERTICES].valid, w_pass_end)
    `DGSP_ASSERT_IMPLY(a_result_from_readout, i_clk, i_rst_n, o_result_valid, $past(r_state == S_OUT))
    `DGSP_ASSERT_IMPLY(a_last_frees_unit, i_clk, i_rst_n, o_result_valid && o_last_of_run, !busy)

endmodule

`default_nettype wire

// ===== rtl/core/dgsp_ram.sv =====
// ============================================================================
// dgsp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module dgsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/dgsp_cell.sv =====
// ============================================================================
// dgsp_cell
// One vertex of the chain: holds its distance and settled flag, settles and
// relaxes against the passing token, and updates the running minimum.
// ============================================================================
`default_nettype none

module dgsp_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dgsp_pkg::t_cell_ctl i_ctl,
    input  wire dgsp_pkg::t_vidx     i_idx,
    input  wire logic                i_init_src,
    input  wire dgsp_pkg::t_weight   i_weight,
    input  wire dgsp_pkg::t_token    i_tok,
    output dgsp_pkg::t_token         o_tok,
    input  wire dgsp_pkg::t_dist     i_shift_dist,
    output dgsp_pkg::t_dist          o_dist
);

    import dgsp_pkg::*;

    t_dist            r_dist;
    logic             r_settled;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_settled_now;
    logic [SUM_W-1:0] w_sum;
    t_dist            w_sat;
    logic             w_relax;
    t_dist            w_dist_new;

    // Settle, relax, then compete for the next pick
    always_comb begin
        w_settled_now = r_settled | (i_tok.settle_en & (i_tok.pick_idx == i_idx));
        w_sum         = SUM_W'(i_tok.pick_dist) + SUM_W'(i_weight);
        w_sat         = (w_sum > SUM_W'(DIST_INF)) ? DIST_INF : w_sum[DIST_W-1:0];
        w_relax       = i_tok.relax_en & ~w_settled_now & (i_weight != '0)
                        & (w_sat < r_dist);
        w_dist_new    = w_relax ? w_sat : r_dist;

        n_tok = i_tok;
        if (~w_settled_now && (w_dist_new <= i_tok.least)) begin
            n_tok.least    = w_dist_new;
            n_tok.best_idx = i_idx;
            n_tok.found    = 1'b1;
        end
    end

    // Hold vertex state: load on init, shift on readout, update under token
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_dist    <= i_init_src ? '0 : DIST_INF;
            r_settled <= 1'b0;
        end else if (i_ctl.shift) begin
            r_dist <= i_shift_dist;
        end else if (i_tok.valid) begin
            r_dist    <= w_dist_new;
            r_settled <= w_settled_now;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok.valid ? n_tok : '0;
        end
    end

    assign o_tok  = r_tok;
    assign o_dist = r_dist;

endmodule

`default_nettype wire

// ===== bench/dense_graph_shortest_paths_unit_tb.sv =====
// ============================================================================
// dense_graph_shortest_paths_unit_tb
// Drives edge weight writes and source runs into the shortest-path unit and
// checks every emitted distance word against an in-bench shortest-path solver.
// A queue of pending command words feeds a clocked driver with random idle
// bursts; a clocked monitor compares each result word with the oldest
// expected word and runs a watchdog on cycles without any accepted word.
// ============================================================================
`default_nettype none

module dense_graph_shortest_paths_unit_tb;

    import dgsp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 400;
    localparam int RAND_ITEMS  = 330;
    localparam int QUIET_TAIL  = 30;

    // One command word as queued for the driver
    typedef struct {
        t_action             action;
        logic [VFIELD_W-1:0] row;
        logic [VFIELD_W-1:0] col;
        logic [WFIELD_W-1:0] weight;
        logic [VFIELD_W-1:0] src;
        logic                wait_drain;
    } t_cmd_word;

    // One distance word as the unit should emit it
    typedef struct {
        logic [VFIELD_W-1:0] vertex;
        t_dist               path_dist;
        logic                reachable;
        logic                last;
    } t_dist_word;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic                i_action        = 1'b0;
    logic [VFIELD_W-1:0] i_row_index     = '0;
    logic [VFIELD_W-1:0] i_column_index  = '0;
    logic [WFIELD_W-1:0] i_edge_weight   = '0;
    logic [VFIELD_W-1:0] i_source_vertex = '0;
    logic                o_result_valid;
    logic [VFIELD_W-1:0] o_vertex_index;
    logic [DIST_W-1:0]   o_path_distance;
    logic                o_reachable;
    logic                o_last_of_run;

    t_cmd_word  cmd_q[$];
    t_dist_word dist_q[$];

    // Solver copy of the edge weight RAM
    t_weight edge_w [RAM_DEPTH];

    int mismatch_cnt = 0;
    int gap_left     = 0;
    int stall_cycles = 0;

    dense_graph_shortest_paths_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_edge_weight   (i_edge_weight),
        .i_source_vertex (i_source_vertex),
        .o_result_valid  (o_result_valid),
        .o_vertex_index  (o_vertex_index),
        .o_path_distance (o_path_distance),
        .o_reachable     (o_reachable),
        .o_last_of_run   (o_last_of_run)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Solve single-source distances and queue one word per emitted vertex
    task automatic solve_paths(input logic [VFIELD_W-1:0] src);
        t_dist            dist_v [NUM_VERTICES];
        logic             settled [NUM_VERTICES];
        t_dist            least;
        int               pick;
        logic             found;
        t_weight          w;
        logic [DIST_W:0]  sum;
        t_dist_word       word;
        for (int v = 0; v < NUM_VERTICES; v++) begin
            dist_v[v]  = DIST_INF;
            settled[v] = 1'b0;
        end
        // An out-of-range source leaves every vertex at infinity
        if (int'(src) < NUM_VERTICES) begin
            dist_v[int'(src)] = '0;
        end
        for (int r = 0; r < NUM_VERTICES - 1; r++) begin
            least = DIST_INF;
            pick  = 0;
            found = 1'b0;
            // Pick the least unsettled distance, highest index on a tie
            for (int v = 0; v < NUM_VERTICES; v++) begin
                if (!settled[v] && dist_v[v] <= least) begin
                    least = dist_v[v];
                    pick  = v;
                    found = 1'b1;
                end
            end
            if (found) begin
                settled[pick] = 1'b1;
                // Never relax from a vertex left at infinity
                if (dist_v[pick] != DIST_INF) begin
                    for (int v = 0; v < NUM_VERTICES; v++) begin
                        w = edge_w[pick * NUM_VERTICES + v];
                        if (!settled[v] && w != '0) begin
                            sum = {1'b0, dist_v[pick]} + (DIST_W + 1)'(w);
                            if (sum > {1'b0, DIST_INF}) begin
                                sum = {1'b0, DIST_INF};
                            end
                            if (sum[DIST_W-1:0] < dist_v[v]) begin
                                dist_v[v] = sum[DIST_W-1:0];
                            end
                        end
                    end
                end
            end
        end
        for (int v = 0; v < OUT_COUNT; v++) begin
            word.vertex    = VFIELD_W'(v);
            word.path_dist = dist_v[v];
            word.reachable = (dist_v[v] != DIST_INF);
            word.last      = (v == OUT_COUNT - 1);
            dist_q.push_back(word);
        end
    endtask

    // Queue an edge weight write; the source field carries noise
    task automatic add_write(input int r, input int c, input int w);
        t_cmd_word cw;
        cw.action     = ACT_WRITE;
        cw.row        = VFIELD_W'(r);
        cw.col        = VFIELD_W'(c);
        cw.weight     = WFIELD_W'(w);
        cw.src        = VFIELD_W'($urandom);
        cw.wait_drain = 1'b0;
        cmd_q.push_back(cw);
    endtask

    // Queue a run; the write fields carry noise
    task automatic add_run(input int s, input logic drain);
        t_cmd_word cw;
        cw.action     = ACT_RUN;
        cw.row        = VFIELD_W'($urandom);
        cw.col        = VFIELD_W'($urandom);
        cw.weight     = WFIELD_W'($urandom);
        cw.src        = VFIELD_W'(s);
        cw.wait_drain = drain;
        cmd_q.push_back(cw);
    endtask

    // Driver: present the oldest pending word, predict on acceptance
    always @(posedge i_clk) begin : drive_cmd
        t_cmd_word cw;
        logic      present;
        present = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                cw = cmd_q.pop_front();
                if (cw.action == ACT_WRITE) begin
                    edge_w[int'(cw.row) * NUM_VERTICES + int'(cw.col)] =
                        cw.weight[WEIGHT_BITS-1:0];
                end else begin
                    solve_paths(cw.src);
                end
            end
            // Open an idle burst now and then, none near the end
            if (gap_left == 0 && cmd_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 14);
            end
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
            end else if (cmd_q.size() != 0) begin
                present = !cmd_q[0].wait_drain || dist_q.size() == 0;
            end
        end
        if (present) begin
            i_action        <= cmd_q[0].action;
            i_row_index     <= cmd_q[0].row;
            i_column_index  <= cmd_q[0].col;
            i_edge_weight   <= cmd_q[0].weight;
            i_source_vertex <= cmd_q[0].src;
        end
        start <= present;
    end

    // Monitor: compare each result word with the oldest expected word
    always @(posedge i_clk) begin : check_result
        t_dist_word ew;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (dist_q.size() == 0) begin
                    $display("%0t: unexpected result word, vertex %0d distance %0d",
                             $time, o_vertex_index, o_path_distance);
                    mismatch_cnt++;
                end else begin
                    ew = dist_q.pop_front();
                    if (o_vertex_index !== ew.vertex) begin
                        $display("%0t: vertex_index expected %0d actual %0d",
                                 $time, ew.vertex, o_vertex_index);
                        mismatch_cnt++;
                    end
                    if (o_path_distance !== ew.path_dist) begin
                        $display("%0t: path_distance of vertex %0d expected %0d actual %0d",
                                 $time, ew.vertex, ew.path_dist, o_path_distance);
                        mismatch_cnt++;
                    end
                    if (o_reachable !== ew.reachable) begin
                        $display("%0t: reachable of vertex %0d expected %0d actual %0d",
                                 $time, ew.vertex, ew.reachable, o_reachable);
                        mismatch_cnt++;
                    end
                    if (o_last_of_run !== ew.last) begin
                        $display("%0t: last_of_run of vertex %0d expected %0d actual %0d",
                                 $time, ew.vertex, ew.last, o_last_of_run);
                        mismatch_cnt++;
                    end
                end
            end
            // Watchdog on cycles where no word moves either way
            if (o_result_valid || (start && !busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int mode;
        int nwr;
        int r;
        int c;
        int w;
        for (int a = 0; a < RAM_DEPTH; a++) begin
            edge_w[a] = '0;
        end

        // Empty graph: only the source is reachable, the rest settle at infinity
        add_run(0, 1'b0);
        add_write(15, 15, 16'hFFFF);
        add_write(0, 15, 16'hFFFF);
        add_write(15, 0, 1);
        add_write(0, 1, 5);
        add_write(1, 15, 5);
        add_write(15, 14, 16'hFFFF);
        add_write(14, 13, 16'hFFFE);
        add_run(0, 1'b1);
        add_run(15, 1'b0);
        // Delete an edge with a zero weight
        add_write(1, 15, 0);
        add_run(0, 1'b0);
        // Self loop and ties: two equal routes to one vertex
        add_write(3, 3, 7);
        add_write(3, 4, 2);
        add_write(3, 5, 2);
        add_write(4, 6, 3);
        add_write(5, 6, 3);
        add_run(3, 1'b0);
        // Long chain of heaviest weights
        for (int k = 6; k < 12; k++) begin
            add_write(k, k + 1, 16'hFFFF);
        end
        add_run(3, 1'b1);

        // Random graph edits, each batch closed by a run
        while (cmd_q.size() < RAND_ITEMS) begin
            mode = $urandom_range(0, 4);
            nwr  = $urandom_range(0, 16);
            for (int k = 0; k < nwr; k++) begin
                r = $urandom_range(0, NUM_VERTICES - 1);
                c = $urandom_range(0, NUM_VERTICES - 1);
                case (mode)
                    0: w = $urandom_range(1, 15);
                    1: w = $urandom_range(0, 65535);
                    2: w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300);
                    3: begin
                        // Chain edges make long multi-hop paths
                        r = $urandom_range(0, NUM_VERTICES - 2);
                        c = r + 1;
                        w = $urandom_range(1, 40);
                    end
                    default: w = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'hFFFE;
                endcase
                add_write(r, c, w);
            end
            add_run($urandom_range(0, NUM_VERTICES - 1), $urandom_range(0, 4) == 0);
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain all pending and expected words, then let the unit settle
        while (cmd_q.size() != 0 || dist_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (dist_q.size() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time, dist_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
